/* rtl/word36_to_byte_packer_unit_defines.svh */
// ---------------------------------------------------------------------------
// word36_to_byte_packer_unit_defines.svh
// Assertion macros shared by the 36-bit word to byte packer RTL.
// ---------------------------------------------------------------------------
`ifndef WORD36_TO_BYTE_PACKER_UNIT_DEFINES_SVH
`define WORD36_TO_BYTE_PACKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked on every rising edge outside reset
`define W36BP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packer assertion failed");
// next-cycle implication
`define W36BP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packer assertion failed");
`else
`define W36BP_ASSERT_NOW(lbl, ante, cons)
`define W36BP_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* rtl/w36bp_pkg.sv */
// ---------------------------------------------------------------------------
// w36bp_pkg
// Widths, constants and action codes of the 36-bit word to byte packer.
// ---------------------------------------------------------------------------
package w36bp_pkg;

  localparam int WORD_W    = 36;
  localparam int S_TDATA_W = 40;
  localparam int BYTE_W    = 8;
  localparam int NIB_W     = 4;
  localparam int SLOT_W    = 40;
  localparam int CNT_W     = 3;

  localparam logic [CNT_W-1:0] CNT_NONE  = 3'd0;
  localparam logic [CNT_W-1:0] CNT_ONE   = 3'd1;
  localparam logic [CNT_W-1:0] CNT_FOUR  = 3'd4;
  localparam logic [CNT_W-1:0] CNT_FIVE  = 3'd5;

  typedef enum logic {
    ACT_PACK  = 1'b0,
    ACT_FLUSH = 1'b1
  } action_t;

endpackage

/* rtl/word36_to_byte_packer_unit.sv */
// ---------------------------------------------------------------------------
// word36_to_byte_packer_unit
// Packs 36-bit words into a big-endian byte stream, two words per 9 bytes.
// ---------------------------------------------------------------------------
// Input stream s_*: one transfer per word or flush. s_tuser[0] is the action
// (0 pack s_tdata[35:0], 1 flush the pending nibble). Output stream m_*: one
// byte per transfer, m_tlast high on the final byte caused by an input.
// A word with no nibble pending gives 4 bytes and keeps its low nibble; a
// word with a nibble pending gives 5 bytes; a flush gives 1 byte or none.
// The first byte of an item passes from the input transfer into the byte
// slot and then into the output register on m_*. Throughput is set by the
// byte-wide output register: the slot gives one byte per output transfer,
// and the next item is taken in the cycle its last byte leaves the byte
// slot.
// Reset clears the pending nibble, the byte slot's valid flag and count, and m_tvalid.
// When m_tready is low, the output byte holds, the slot holds, and s_tready
// drops once the slot is occupied.
// ---------------------------------------------------------------------------
`include "word36_to_byte_packer_unit_defines.svh"

module word36_to_byte_packer_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [w36bp_pkg::S_TDATA_W-1:0] s_tdata,  // [35:0] data_word, [39:36] zero
  input  logic [0:0]                      s_tuser,  // [0] action
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [w36bp_pkg::BYTE_W-1:0]    m_tdata,  // [7:0] out_byte
  output logic                            m_tlast
);

  import w36bp_pkg::*;

  logic                 pending;
  logic                 pending_next;
  logic [NIB_W-1:0]     held_nib;
  logic [NIB_W-1:0]     held_nib_next;
  logic                 slot_valid;
  logic [SLOT_W-1:0]    slot_bytes;
  logic [CNT_W-1:0]     slot_cnt;
  logic [SLOT_W-1:0]    load_bytes;
  logic [CNT_W-1:0]     load_cnt;
  logic                 out_free;
  logic                 s_xfer;
  logic [WORD_W-1:0]    word;
  action_t              action;

  assign word     = s_tdata[WORD_W-1:0];
  assign action   = action_t'(s_tuser[0]);
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = !slot_valid || (out_free && (slot_cnt == CNT_ONE));
  assign s_xfer   = s_tvalid && s_tready;

  always_comb begin
    pending_next  = pending;
    held_nib_next = held_nib;
    load_bytes    = '0;
    load_cnt      = CNT_NONE;
    unique case (action)
      ACT_FLUSH: begin
        if (pending) begin
          load_bytes   = {held_nib, {(SLOT_W-NIB_W){1'b0}}};
          load_cnt     = CNT_ONE;
          pending_next = 1'b0;
        end
      end
      ACT_PACK: begin
        if (pending) begin
          load_bytes   = {held_nib, word};
          load_cnt     = CNT_FIVE;
          pending_next = 1'b0;
        end else begin
          load_bytes    = {word[WORD_W-1:NIB_W], {BYTE_W{1'b0}}};
          load_cnt      = CNT_FOUR;
          held_nib_next = word[NIB_W-1:0];
          pending_next  = 1'b1;
        end
      end
      default: begin
        load_cnt = CNT_NONE;
      end
    endcase
  end

  // pack state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= 1'b0;
      held_nib <= '0;
    end else if (s_xfer) begin
      pending  <= pending_next;
      held_nib <= held_nib_next;
    end
  end

  // byte slot: drain one byte per output transfer, reload on input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_cnt   <= CNT_NONE;
    end else begin
      if (slot_valid && out_free) begin
        slot_cnt <= slot_cnt - CNT_ONE;
        if (slot_cnt == CNT_ONE) begin
          slot_valid <= 1'b0;
        end
      end
      if (s_xfer) begin
        slot_valid <= (load_cnt != CNT_NONE);
        slot_cnt   <= load_cnt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_xfer) begin
      slot_bytes <= load_bytes;
    end else if (slot_valid && out_free) begin
      slot_bytes <= {slot_bytes[SLOT_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= slot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && slot_valid) begin
      m_tdata <= slot_bytes[SLOT_W-1:SLOT_W-BYTE_W];
      m_tlast <= (slot_cnt == CNT_ONE);
    end
  end

  `W36BP_ASSERT_NOW(a_slot_cnt_range, slot_valid,
    (slot_cnt != CNT_NONE) && (slot_cnt <= CNT_FIVE))
  `W36BP_ASSERT_NEXT(a_last_byte_out, slot_valid && out_free && (slot_cnt == CNT_ONE),
    m_tvalid && m_tlast)
  `W36BP_ASSERT_NEXT(a_pack_sets_pending, s_xfer && (action == ACT_PACK) && !pending,
    pending && slot_valid && (slot_cnt == CNT_FOUR))
  `W36BP_ASSERT_NEXT(a_flush_clears_pending, s_xfer && (action == ACT_FLUSH), !pending)

endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the 36-bit word to byte packer.
// ---------------------------------------------------------------------------
// Words and flushes go in on s_*. A local model of the nibble state predicts
// the big-endian byte stream and the per-item tlast marker. Every output
// transfer is checked against the oldest predicted byte. The run has a
// directed part, random streams under several idle and stall mixes, and a
// long receiver hold-off that backs the block up into its input.
// ---------------------------------------------------------------------------
module tb;
  import w36bp_pkg::*;

  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic [BYTE_W-1:0] val;
    logic              last;
  } packed_byte_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;  // [35:0] data_word, [39:36] zero
  logic [0:0]           s_tuser = '0;  // [0] action
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [BYTE_W-1:0]    m_tdata;       // [7:0] out_byte
  logic                 m_tlast;

  packed_byte_t        byte_stream_q[$];
  logic                nib_pending = 1'b0;
  logic [NIB_W-1:0]    held_nib = '0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  hold_len = 0;
  int                  hold_left = 0;
  int                  cycle_cnt = 0;
  int                  err_cnt = 0;
  int                  words_sent = 0;
  int                  flushes_sent = 0;
  int                  bytes_checked = 0;

  word36_to_byte_packer_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void push_byte(logic [BYTE_W-1:0] val, logic last);
    packed_byte_t b;
    b.val  = val;
    b.last = last;
    byte_stream_q.push_back(b);
  endfunction

  function automatic void predict_packing(action_t act, logic [WORD_W-1:0] w);
    if (act == ACT_FLUSH) begin
      if (nib_pending) begin
        push_byte({held_nib, 4'h0}, 1'b1);
        nib_pending = 1'b0;
      end
    end else if (nib_pending) begin
      push_byte({held_nib, w[35:32]}, 1'b0);
      push_byte(w[31:24], 1'b0);
      push_byte(w[23:16], 1'b0);
      push_byte(w[15:8], 1'b0);
      push_byte(w[7:0], 1'b1);
      nib_pending = 1'b0;
    end else begin
      push_byte(w[35:28], 1'b0);
      push_byte(w[27:20], 1'b0);
      push_byte(w[19:12], 1'b0);
      push_byte(w[11:4], 1'b1);
      held_nib    = w[3:0];
      nib_pending = 1'b1;
    end
  endfunction

  task automatic send_item(input action_t act, input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_TDATA_W-WORD_W){1'b0}}, w};
    s_tuser  <= act;
    do @(posedge clk); while (!s_tready);
    predict_packing(act, w);
    if (act == ACT_FLUSH) flushes_sent++;
    else words_sent++;
  endtask

  task automatic wait_stream_empty();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (byte_stream_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    packed_byte_t exp_b;
    if (!rst && m_tvalid && m_tready) begin
      if (byte_stream_q.size() == 0) begin
        $error("unexpected byte transfer: out_byte=%h last_byte=%b", m_tdata, m_tlast);
        err_cnt++;
      end else begin
        exp_b = byte_stream_q.pop_front();
        bytes_checked++;
        if (m_tdata !== exp_b.val) begin
          $error("out_byte mismatch: expected %h, actual %h", exp_b.val, m_tdata);
          err_cnt++;
        end
        if (m_tlast !== exp_b.last) begin
          $error("last_byte mismatch: expected %b, actual %b", exp_b.last, m_tlast);
          err_cnt++;
        end
      end
    end
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(ACT_FLUSH, 36'h0_0000_0000);
    send_item(ACT_PACK,  36'h0_0000_0000);
    send_item(ACT_PACK,  36'hF_FFFF_FFFF);
    send_item(ACT_FLUSH, 36'hF_FFFF_FFFF);
    send_item(ACT_PACK,  36'hF_FFFF_FFFF);
    send_item(ACT_FLUSH, 36'h0_0000_0000);
    send_item(ACT_FLUSH, 36'hF_FFFF_FFFF);
    send_item(ACT_PACK,  36'h8_0000_0001);
    send_item(ACT_PACK,  36'h1_2345_6789);
    send_item(ACT_PACK,  36'hA_BCDE_F012);
    send_item(ACT_PACK,  36'h5_A5A5_A5A5);
    send_item(ACT_PACK,  36'hA_5A5A_5A5A);
    send_item(ACT_PACK,  36'h0_0000_000F);
    send_item(ACT_FLUSH, 36'h0_0000_0000);
    send_item(ACT_PACK,  36'hF_FFFF_FFF0);
    send_item(ACT_PACK,  36'h0_0000_0000);
    send_item(ACT_FLUSH, 36'h0_0000_0000);
    send_item(ACT_PACK,  36'h7_FFFF_FFFE);
    send_item(ACT_PACK,  36'h8_0000_0000);
    send_item(ACT_PACK,  36'h0_0000_0001);
    send_item(ACT_FLUSH, 36'h0_0000_0000);
    wait_stream_empty();
  endtask

  task automatic test_random_stream(input int n, input int idle, input int stall);
    logic [WORD_W-1:0] w;
    int                sel;
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      w   = {4'($urandom_range(15)), 32'($urandom)};
      if (sel < 5) w = '0;
      else if (sel < 10) w = '1;
      if (sel >= 85) send_item(ACT_FLUSH, w);
      else send_item(ACT_PACK, w);
    end
    wait_stream_empty();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_len      = 80;
    for (int i = 0; i < 14; i++) begin
      if (i % 5 == 4) send_item(ACT_FLUSH, {4'($urandom_range(15)), 32'($urandom)});
      else send_item(ACT_PACK, {4'($urandom_range(15)), 32'($urandom)});
    end
    wait_stream_empty();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_stream(36, 0, 0);
    test_random_stream(36, 49, 0);
    test_random_stream(36, 0, 49);
    test_random_stream(36, 13, 13);
    test_backpressure();
    wait_stream_empty();
    repeat (10) @(posedge clk);
    if (byte_stream_q.size() != 0) begin
      $error("%0d predicted bytes never arrived", byte_stream_q.size());
      err_cnt++;
    end
    $display("Covered %0d words and %0d flushes, %0d bytes checked,",
             words_sent, flushes_sent, bytes_checked);
    $display("under idle, stall and long hold-off mixes on both streams.");
    if (err_cnt == 0) begin
      $display("** word36_to_byte_packer_unit: PASSED **");
    end else begin
      $display("** word36_to_byte_packer_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles", cycle_cnt);
    $display("** word36_to_byte_packer_unit: FAILED **");
    $finish;
  end

endmodule
